### src/q2va_pkg.sv
// Package for the quaternion-to-voxel affine pipeline: widths, types and helpers.
// No dependencies.
`timescale 1ns / 1ps
package q2va_pkg;

    localparam int QW        = 16;  // Q1.14 quaternion component width
    localparam int SQW       = 32;  // Q.28 square width (signed)
    localparam int REMW      = 30;  // max(0, rem) fits in 30 bits (<= 2^28)
    localparam int RADW      = 58;  // radicand rem << 28
    localparam int AW        = 29;  // a in Q.28, a <= 2^28
    localparam int MW        = 52;  // matrix terms in Q.42, signed
    localparam int ML        = 26;  // low slice of a matrix term for the split multiply
    localparam int PPW       = 43;  // partial product width, 26 by 17 bits
    localparam int PW        = 69;  // scaled product, signed
    localparam int EW        = 17;  // output entry width
    localparam int SQRT_STEPS = 29; // one result bit per stage
    localparam logic [16:0] ENTRY_MAX = 17'd65535;

    typedef logic signed [QW-1:0]  quat_t;
    typedef logic [15:0]           spacing_t;
    typedef logic signed [31:0]    shift_t;
    typedef logic signed [EW-1:0]  entry_t;

    // Side data that rides along the pipeline with each item.
    typedef struct packed {
        quat_t    b;
        quat_t    c;
        quat_t    d;
        logic     flip;
        spacing_t si;
        spacing_t sj;
        spacing_t sk;
        shift_t   tx;
        shift_t   ty;
        shift_t   tz;
    } side_t;

    // Round a Q.50 product to Q.8, ties away from zero, saturate.
    function automatic entry_t round_sat(input logic signed [PW-1:0] p);
        logic            neg;
        logic [PW-1:0]   mag;
        logic [PW-1:0]   r;
        logic [EW-2:0]   lim;
        begin
            neg = p[PW-1];
            mag = neg ? PW'(-p) : PW'(p);
            r = (mag + (PW'(1) << 41)) >> 42;
            lim = (r > PW'(ENTRY_MAX)) ? ENTRY_MAX[EW-2:0] : r[EW-2:0];
            round_sat = neg ? -entry_t'({1'b0, lim}) : entry_t'({1'b0, lim});
        end
    endfunction

endpackage

### src/quaternion_to_voxel_affine_top.sv
// Top level of the quaternion-to-voxel affine pipeline.
// Depends on q2va_pkg, q2va_sqrt and q2va_matrix.
`timescale 1ns / 1ps
//
// Channel | Direction | Handshake        | Payload
// --------+-----------+------------------+-------------------------------------
// input   | in        | in_valid/in_ready| quat_b/c/d, flip_k, spacing_*, shift_*
// output  | out       | out_valid/out_ready | row*_col*, trans_x/y/z
//
// One beat is accepted per cycle while the output is not stalled. The pipeline
// holds 35 register stages: one stage for the squares and remainder, 29 stages
// of the bit-per-stage square root, four matrix stages and the output register.
// The whole pipeline advances only when the output register is empty or being
// drained, so a stall freezes every stage and nothing is dropped or repeated.
// Reset clears only the valid bits.
module quaternion_to_voxel_affine_top
    import q2va_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  quat_t         quat_b,
    input  quat_t         quat_c,
    input  quat_t         quat_d,
    input  logic          flip_k,
    input  spacing_t      spacing_i,
    input  spacing_t      spacing_j,
    input  spacing_t      spacing_k,
    input  shift_t        shift_x,
    input  shift_t        shift_y,
    input  shift_t        shift_z,
    output logic          out_valid,
    input  logic          out_ready,
    output entry_t        row0_col0,
    output entry_t        row0_col1,
    output entry_t        row0_col2,
    output entry_t        row1_col0,
    output entry_t        row1_col1,
    output entry_t        row1_col2,
    output entry_t        row2_col0,
    output entry_t        row2_col1,
    output entry_t        row2_col2,
    output shift_t        trans_x,
    output shift_t        trans_y,
    output shift_t        trans_z
);

    logic en;
    // The chain moves whenever the final register can take a new item.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Stage 0: remainder 1 - b^2 - c^2 - d^2, clamped at zero.
    logic signed [SQW+1:0] rem_c;
    logic [REMW-1:0]       rem0_reg;
    side_t                 sd0_reg;
    logic                  v0_reg;

    always_comb
    begin
        rem_c = (SQW+2)'(1 << 28) - (SQW+2)'(quat_b * quat_b)
              - (SQW+2)'(quat_c * quat_c) - (SQW+2)'(quat_d * quat_d);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem0_reg <= rem_c[SQW+1] ? '0 : rem_c[REMW-1:0];
            sd0_reg  <= '{b: quat_b, c: quat_c, d: quat_d, flip: flip_k,
                          si: spacing_i, sj: spacing_j, sk: spacing_k,
                          tx: shift_x, ty: shift_y, tz: shift_z};
        end
    end

    // Square root of rem << 28 gives a in Q.28.
    logic            sq_valid;
    logic [AW-1:0]   a_root;
    logic [REMW-1:0] sq_rem;
    side_t           sq_side;

    q2va_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v0_reg),
        .radicand  ({rem0_reg, 28'd0}),
        .rem_in    (rem0_reg),
        .side_in   (sd0_reg),
        .out_valid (sq_valid),
        .root      (a_root),
        .rem_out   (sq_rem),
        .side_out  (sq_side)
    );

    logic   mx_valid;
    entry_t mx_ent [9];
    side_t  mx_side;

    q2va_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .a         (a_root),
        .rem       (sq_rem),
        .side_in   (sq_side),
        .out_valid (mx_valid),
        .m_out     (mx_ent),
        .side_out  (mx_side)
    );

    // Output register.
    logic   ov_reg;
    entry_t oe_reg [9];
    side_t  os_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= mx_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oe_reg <= mx_ent;
            os_reg <= mx_side;
        end
    end

    assign out_valid = ov_reg;
    assign row0_col0 = oe_reg[0];
    assign row0_col1 = oe_reg[1];
    assign row0_col2 = oe_reg[2];
    assign row1_col0 = oe_reg[3];
    assign row1_col1 = oe_reg[4];
    assign row1_col2 = oe_reg[5];
    assign row2_col0 = oe_reg[6];
    assign row2_col1 = oe_reg[7];
    assign row2_col2 = oe_reg[8];
    assign trans_x   = os_reg.tx;
    assign trans_y   = os_reg.ty;
    assign trans_z   = os_reg.tz;

    // A stalled result must hold its trans_x and its row0_col0 entry.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(trans_x) && $stable(row0_col0))
        else $error("result changed during stall");

    // Entries never reach the unused most negative code.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row1_col1 != 17'h10000 && row0_col2 != 17'h10000)
        else $error("entry saturation out of range");

    // The pipeline stands still exactly when the output is stalled.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sq_valid) && $stable(mx_valid))
        else $error("pipeline moved during stall");

endmodule

### src/q2va_sqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on q2va_pkg.
`timescale 1ns / 1ps
module q2va_sqrt
    import q2va_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RADW-1:0]     radicand,
    input  logic [REMW-1:0]     rem_in,
    input  side_t               side_in,
    output logic                out_valid,
    output logic [AW-1:0]       root,
    output logic [REMW-1:0]     rem_out,
    output side_t               side_out
);

    // Remainder needs up to root-width+2 bits.
    localparam int RW = AW + 2;

    logic [RADW-1:0] x_reg   [SQRT_STEPS+1];
    logic [RW-1:0]   r_reg   [SQRT_STEPS+1];
    logic [AW-1:0]   q_reg   [SQRT_STEPS+1];
    logic [REMW-1:0] rm_reg  [SQRT_STEPS+1];
    side_t           sd_reg  [SQRT_STEPS+1];
    logic            v_reg   [SQRT_STEPS+1];

    always_comb
    begin
        x_reg[0]  = radicand;
        r_reg[0]  = '0;
        q_reg[0]  = '0;
        rm_reg[0] = rem_in;
        sd_reg[0] = side_in;
        v_reg[0]  = in_valid;
    end

    genvar g;
    generate
        for (g = 0; g < SQRT_STEPS; g++)
        begin : g_step
            logic [RW-1:0] trial;
            logic [RW-1:0] rcat;
            always_comb
            begin
                rcat  = {r_reg[g][RW-3:0], x_reg[g][RADW-1 -: 2]};
                trial = {q_reg[g], 2'b01};
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[g+1] <= 1'b0;
                else if (en)
                    v_reg[g+1] <= v_reg[g];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[g+1]  <= x_reg[g] << 2;
                    rm_reg[g+1] <= rm_reg[g];
                    sd_reg[g+1] <= sd_reg[g];
                    if (rcat >= trial)
                    begin
                        r_reg[g+1] <= rcat - trial;
                        q_reg[g+1] <= {q_reg[g][AW-2:0], 1'b1};
                    end
                    else
                    begin
                        r_reg[g+1] <= rcat;
                        q_reg[g+1] <= {q_reg[g][AW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[SQRT_STEPS];
    assign root      = q_reg[SQRT_STEPS];
    assign rem_out   = rm_reg[SQRT_STEPS];
    assign side_out  = sd_reg[SQRT_STEPS];

endmodule

### src/q2va_matrix.sv
// Rotation terms, column scaling, k flip, rounding, saturation in four stages.
// Depends on q2va_pkg.
`timescale 1ns / 1ps
module q2va_matrix
    import q2va_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [AW-1:0]    a,
    input  logic [REMW-1:0]  rem,
    input  side_t            side_in,
    output logic             out_valid,
    output entry_t           m_out [9],
    output side_t            side_out
);

    // Stage 1: pair products.
    logic signed [SQW-1:0] bb_reg, cc_reg, dd_reg, bc_reg, bd_reg, cd_reg;
    logic signed [47:0]    ab_reg, ac_reg, ad_reg;
    logic signed [REMW:0]  rem_reg;
    side_t                 sd1_reg;
    logic                  v1_reg;

    // Stage 2: matrix terms in Q.42.
    logic signed [MW-1:0]  m_reg [9];
    side_t                 sd2_reg;
    logic                  v2_reg;

    // Stage 3: each term times its spacing as two partial products.
    logic [PPW-1:0]        plo_reg [9];
    logic signed [PPW-1:0] phi_reg [9];
    side_t                 sd3_reg;
    logic                  v3_reg;

    // Stage 4: rounded entries.
    entry_t                e_reg [9];
    side_t                 sd4_reg;
    logic                  v4_reg;

    logic signed [AW:0]    a_s;
    assign a_s = {1'b0, a};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb_reg  <= side_in.b * side_in.b;
            cc_reg  <= side_in.c * side_in.c;
            dd_reg  <= side_in.d * side_in.d;
            bc_reg  <= side_in.b * side_in.c;
            bd_reg  <= side_in.b * side_in.d;
            cd_reg  <= side_in.c * side_in.d;
            ab_reg  <= 48'(a_s * side_in.b);
            ac_reg  <= 48'(a_s * side_in.c);
            ad_reg  <= 48'(a_s * side_in.d);
            rem_reg <= {1'b0, rem};
            sd1_reg <= side_in;
        end
    end

    logic signed [MW-1:0] rem_w, bb_w, cc_w, dd_w, bc_w, bd_w, cd_w, ab_w, ac_w, ad_w;
    always_comb
    begin
        rem_w = MW'(rem_reg);
        bb_w  = MW'(bb_reg);
        cc_w  = MW'(cc_reg);
        dd_w  = MW'(dd_reg);
        bc_w  = MW'(bc_reg) <<< 14;
        bd_w  = MW'(bd_reg) <<< 14;
        cd_w  = MW'(cd_reg) <<< 14;
        ab_w  = MW'(ab_reg);
        ac_w  = MW'(ac_reg);
        ad_w  = MW'(ad_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= (rem_w + bb_w - cc_w - dd_w) <<< 14;
            m_reg[1] <= (bc_w - ad_w) <<< 1;
            m_reg[2] <= (bd_w + ac_w) <<< 1;
            m_reg[3] <= (bc_w + ad_w) <<< 1;
            m_reg[4] <= (rem_w + cc_w - bb_w - dd_w) <<< 14;
            m_reg[5] <= (cd_w - ab_w) <<< 1;
            m_reg[6] <= (bd_w - ac_w) <<< 1;
            m_reg[7] <= (cd_w + ab_w) <<< 1;
            m_reg[8] <= (rem_w + dd_w - bb_w - cc_w) <<< 14;
            sd2_reg  <= sd1_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < 9; g++)
        begin : g_ent
            logic signed [16:0]      s_s;
            logic signed [MW-ML-1:0] m_hi;
            logic [ML-1:0]           m_lo;
            logic signed [PW-1:0]    p;
            always_comb
            begin
                case (g % 3)
                    0:       s_s = {1'b0, sd2_reg.si};
                    1:       s_s = {1'b0, sd2_reg.sj};
                    default: s_s = {1'b0, sd2_reg.sk};
                endcase
                m_hi = m_reg[g][MW-1:ML];
                m_lo = m_reg[g][ML-1:0];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    plo_reg[g] <= m_lo * $unsigned(s_s);
                    phi_reg[g] <= m_hi * s_s;
                end
            end
            // The signed upper slice carries the sign; the lower slice is unsigned.
            always_comb
            begin
                p = (PW'(phi_reg[g]) <<< ML) + PW'(plo_reg[g]);
                if ((g % 3 == 2) && sd3_reg.flip)
                    p = -p;
            end
            always_ff @(posedge clk)
            begin
                if (en)
                    e_reg[g] <= round_sat(p);
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd3_reg <= sd2_reg;
            sd4_reg <= sd3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign m_out     = e_reg;
    assign side_out  = sd4_reg;

endmodule
